### src/lps_pkg.sv
// Package for the line pixel stepper: shared types and fixed field widths.
// No dependencies; used by line_pixel_stepper_core.
package lps_pkg;

    // Widths fixed by the result and configuration fields.
    localparam int ADDR_W  = 22;
    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;

    // Action codes carried by an input beat.
    typedef enum logic [0:0] {
        ACT_LOAD = 1'b0,
        ACT_STEP = 1'b1
    } t_action;

endpackage

### src/line_pixel_stepper_core.sv
// Bresenham line stepper core: line set-up, per-pixel stepping, frame-buffer addressing.
// Depends on lps_pkg for the action codes and field widths.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | action, start x/y, end x/y
//  out     | output    | o_out_valid / i_out_stall | pixel x/y, address, in_buffer, colour, last
//  cfg     | input     | i_cfg_we                  | line colour (24 bits)
//
// For each beat the line state registers feed one add, compare and subtract stage and a
// constant multiply for the address, and the pixel lands in the output register on the
// following edge. One pixel per clock is sustained while the output is not stalled.
// A load beat gives no output beat. A step beat while no line is active gives nothing.
// The input stalls only while the output register is full and its own beat is stalled.
// Reset (synchronous, active low) drops any line in progress and clears the colour.
module line_pixel_stepper_core #(
    parameter int SCREEN_W   = 1024,
    parameter int SCREEN_H   = 1024,
    parameter int COORD_BITS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration port.
    input  logic                           i_cfg_we,
    input  logic [lps_pkg::COLOR_W-1:0]    i_cfg_data,
    // Input channel.
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  lps_pkg::t_action               i_action,
    input  logic signed [COORD_BITS-1:0]   i_start_x,
    input  logic signed [COORD_BITS-1:0]   i_start_y,
    input  logic signed [COORD_BITS-1:0]   i_end_x,
    input  logic signed [COORD_BITS-1:0]   i_end_y,
    // Output channel.
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [COORD_BITS-1:0]   o_pixel_x,
    output logic signed [COORD_BITS-1:0]   o_pixel_y,
    output logic [lps_pkg::ADDR_W-1:0]     o_pixel_address,
    output logic                           o_in_buffer,
    output logic [lps_pkg::CHAN_W-1:0]     o_color_red,
    output logic [lps_pkg::CHAN_W-1:0]     o_color_green,
    output logic [lps_pkg::CHAN_W-1:0]     o_color_blue,
    output logic                           o_last
);
    import lps_pkg::*;

    // Stored error term and its working width (twice a sum of two deltas).
    localparam int ERR_W        = COORD_BITS + 1;
    localparam int SUM_W        = COORD_BITS + 3;
    localparam int ROW_STRIDE   = SCREEN_W * 3;
    localparam int ADDR_FULL_W  = $clog2(SCREEN_H * SCREEN_W * 3 + 1);

    // Line state.
    logic signed [COORD_BITS-1:0] r_cur_x, r_cur_y, r_stop_major;
    logic [COORD_BITS-1:0]        r_delta_x_abs, r_delta_y_abs;
    logic signed [ERR_W-1:0]      r_error_sum;
    logic                         r_step_x_neg, r_step_y_neg, r_x_major, r_line_active;
    logic [COLOR_W-1:0]           r_line_color;

    logic signed [COORD_BITS-1:0] n_cur_x, n_cur_y, n_stop_major;
    logic [COORD_BITS-1:0]        n_delta_x_abs, n_delta_y_abs;
    logic signed [ERR_W-1:0]      n_error_sum;
    logic                         n_step_x_neg, n_step_y_neg, n_x_major, n_line_active;

    // Output register.
    logic                         r_out_valid;
    logic signed [COORD_BITS-1:0] r_pixel_x, r_pixel_y;
    logic [ADDR_W-1:0]            r_pixel_address;
    logic                         r_in_buffer, r_last;
    logic [COLOR_W-1:0]           r_out_color;

    logic in_beat, out_beat, emit;

    // Set-up terms for a load beat.
    logic signed [COORD_BITS:0]   ld_dx, ld_dy;
    logic [COORD_BITS-1:0]        ld_adx, ld_ady;
    logic                         ld_x_major;

    // Stepping terms.
    logic [COORD_BITS-1:0]        x_inc, y_inc;
    logic signed [COORD_BITS-1:0] x_adv, y_adv;
    logic [COORD_BITS-1:0]        dmaj, dmin;
    logic signed [SUM_W-1:0]      dmaj_ext, dmin_ext, err_pre, err_twice, err_post;
    logic                         minor_step, step_last;

    // Address terms.
    logic signed [31:0]           px_ext, py_ext;
    logic                         in_frame;
    logic [ADDR_FULL_W-1:0]       row_idx, col_idx, addr_full;

    // Handshake.
    assign out_beat   = r_out_valid && !i_out_stall;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_beat    = i_in_valid && !o_in_stall;
    assign emit       = in_beat && (i_action == ACT_STEP) && r_line_active;

    // Endpoint differences, directions and major axis for a load.
    always_comb begin
        ld_dx      = ERR_W'(i_end_x) - ERR_W'(i_start_x);
        ld_dy      = ERR_W'(i_end_y) - ERR_W'(i_start_y);
        ld_adx     = ld_dx[COORD_BITS] ? COORD_BITS'(-ld_dx) : ld_dx[COORD_BITS-1:0];
        ld_ady     = ld_dy[COORD_BITS] ? COORD_BITS'(-ld_dy) : ld_dy[COORD_BITS-1:0];
        ld_x_major = ld_adx > ld_ady;
    end

    // One Bresenham step: advance the major axis, accumulate the minor delta and
    // move the minor axis once twice the error reaches the major delta.
    always_comb begin
        x_inc      = r_step_x_neg ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
        y_inc      = r_step_y_neg ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
        x_adv      = r_cur_x + $signed(x_inc);
        y_adv      = r_cur_y + $signed(y_inc);
        dmaj       = r_x_major ? r_delta_x_abs : r_delta_y_abs;
        dmin       = r_x_major ? r_delta_y_abs : r_delta_x_abs;
        dmaj_ext   = $signed({{(SUM_W-COORD_BITS){1'b0}}, dmaj});
        dmin_ext   = $signed({{(SUM_W-COORD_BITS){1'b0}}, dmin});
        err_pre    = SUM_W'(r_error_sum) + dmin_ext;
        err_twice  = err_pre <<< 1;
        minor_step = err_twice >= dmaj_ext;
        err_post   = minor_step ? err_pre - dmaj_ext : err_pre;
        step_last  = (r_x_major ? x_adv : y_adv) == r_stop_major;
    end

    // Bottom-up BGR address of the current pixel.
    always_comb begin
        px_ext    = 32'(r_cur_x);
        py_ext    = 32'(r_cur_y);
        in_frame  = (px_ext >= 0) && (px_ext < SCREEN_W)
                    && (py_ext >= 1) && (py_ext <= SCREEN_H);
        row_idx   = ADDR_FULL_W'(SCREEN_H - py_ext);
        col_idx   = ADDR_FULL_W'(px_ext);
        addr_full = row_idx * ADDR_FULL_W'(ROW_STRIDE) + (col_idx << 1) + col_idx;
    end

    // Next line state.
    always_comb begin
        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        n_stop_major  = r_stop_major;
        n_delta_x_abs = r_delta_x_abs;
        n_delta_y_abs = r_delta_y_abs;
        n_error_sum   = r_error_sum;
        n_step_x_neg  = r_step_x_neg;
        n_step_y_neg  = r_step_y_neg;
        n_x_major     = r_x_major;
        n_line_active = r_line_active;
        if (in_beat && (i_action == ACT_LOAD)) begin
            n_cur_x       = i_start_x;
            n_cur_y       = i_start_y;
            n_stop_major  = ld_x_major ? i_end_x : i_end_y;
            n_delta_x_abs = ld_adx;
            n_delta_y_abs = ld_ady;
            n_error_sum   = '0;
            n_step_x_neg  = !(ld_dx > 0);
            n_step_y_neg  = !(ld_dy > 0);
            n_x_major     = ld_x_major;
            n_line_active = ld_x_major ? (i_start_x != i_end_x) : (i_start_y != i_end_y);
        end else if (emit) begin
            n_cur_x       = (r_x_major || minor_step) ? x_adv : r_cur_x;
            n_cur_y       = (!r_x_major || minor_step) ? y_adv : r_cur_y;
            n_error_sum   = ERR_W'(err_post);
            n_line_active = !step_last;
        end
    end

    // Line state registers; only the active flag needs a reset.
    always_ff @(posedge i_clk) begin
        r_cur_x       <= n_cur_x;
        r_cur_y       <= n_cur_y;
        r_stop_major  <= n_stop_major;
        r_delta_x_abs <= n_delta_x_abs;
        r_delta_y_abs <= n_delta_y_abs;
        r_error_sum   <= n_error_sum;
        r_step_x_neg  <= n_step_x_neg;
        r_step_y_neg  <= n_step_y_neg;
        r_x_major     <= n_x_major;
        if (!i_rst_n) begin
            r_line_active <= 1'b0;
        end else begin
            r_line_active <= n_line_active;
        end
    end

    // Colour register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_color <= '0;
        end else if (i_cfg_we) begin
            r_line_color <= i_cfg_data;
        end
    end

    // Output register: loaded by an emitting step, emptied when its beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (out_beat) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_pixel_x       <= r_cur_x;
            r_pixel_y       <= r_cur_y;
            r_pixel_address <= in_frame ? ADDR_W'(addr_full) : '0;
            r_in_buffer     <= in_frame;
            r_out_color     <= r_line_color;
            r_last          <= step_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pixel_x       = r_pixel_x;
    assign o_pixel_y       = r_pixel_y;
    assign o_pixel_address = r_pixel_address;
    assign o_in_buffer     = r_in_buffer;
    assign o_color_red     = r_out_color[3*CHAN_W-1:2*CHAN_W];
    assign o_color_green   = r_out_color[2*CHAN_W-1:CHAN_W];
    assign o_color_blue    = r_out_color[CHAN_W-1:0];
    assign o_last          = r_last;

    // A stepping beat on an active line always leaves a pixel in the output register.
    a_step_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && (i_action == ACT_STEP) && r_line_active) |=> o_out_valid)
        else $error("active step did not produce a pixel");

    // The final pixel of a line leaves the stepper idle.
    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && step_last) |=> !r_line_active)
        else $error("line still active after its final pixel");

    // Pixels outside the buffer carry a zero address.
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_in_buffer) |-> (o_pixel_address == '0))
        else $error("outside pixel has a non-zero address");

    // The error term stays within half the major delta either side while drawing.
    a_error_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_active |-> ((SUM_W'(r_error_sum) <<< 1) <= dmaj_ext)
                       && ((SUM_W'(r_error_sum) <<< 1) >= -dmaj_ext))
        else $error("error term out of range");

endmodule
